@@ rtl/json_string_unescaper_macros.svh @@
// Assertion macros for the JSON string unescaper.
// Used by the top level; relies on clk_i and rst_ni in the including module.
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define JSU_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("jsu assertion failed");

// Next-cycle implication, disabled during reset
`define JSU_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("jsu assertion failed");

`endif

@@ rtl/jsu_pkg.sv @@
// Shared types and constants of the JSON string unescaper.
// No dependencies; used by jsu_res_queue, json_string_unescaper, the checker and the testbench.
package jsu_pkg;

  // Most results one source byte can cause, and width of a count of them
  localparam int MAX_RES = 8;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  // Defaults for the top-level parameters
  localparam int HEADER_BYTES_DEF = 8;
  localparam int PAD_ALIGN_DEF    = 8;

  // Reset value of the capacity register
  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_DST_OVF  = 3'd1,
    ERR_SRC_OVF  = 3'd2,
    ERR_BAD_UNI  = 3'd3,
    ERR_BAD_ESC  = 3'd4,
    ERR_BAD_CHAR = 3'd5
  } err_e;

  // Input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_last;
  } jsu_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] str_length;
    logic [2:0]  error_code;
    logic        run_last;
  } jsu_out_t;

  // All results caused by one input item
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    jsu_out_t [MAX_RES-1:0]       items;
  } jsu_burst_t;

endpackage

@@ rtl/json_string_unescaper.sv @@
// JSON string unescaper top level: decoder state, capacity register, result queue.
// Depends on jsu_pkg, jsu_res_queue and json_string_unescaper_macros.svh.
//
// Source bytes of one JSON string, opening quote first, go in one item per
// cycle while the result queue can take them; each byte is decoded
// combinationally into a burst of zero to MAX_RES results that is registered
// in a small result queue and leaves on the output one result per cycle
// while out_ready_i is high. The next input item waits until the byte's last
// result leaves (plain bytes and simple escapes give one data byte; a \uXXXX
// escape ends with up to three data bytes; the closing quote sends up to
// MAX_RES-1 padding bytes plus the done item). The next item is taken in the same
// cycle as the last result of the previous one. The capacity register is
// written through its own port, which is always ready.
`include "json_string_unescaper_macros.svh"

module json_string_unescaper
  import jsu_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int PAD_ALIGN    = PAD_ALIGN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  jsu_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output jsu_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // Width of length modulo PAD_ALIGN plus up to three new bytes
  localparam int PW = $clog2(PAD_ALIGN + 4);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TEXT = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  // Hex digit: {valid, value}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  // Simple escape: {ok, is_unicode, byte}
  function automatic logic [9:0] esc_value(logic [7:0] c);
    logic [9:0] r;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r = {2'b10, c};
      8'h62:   r = {2'b10, 8'h08};  // b
      8'h66:   r = {2'b10, 8'h0C};  // f
      8'h6E:   r = {2'b10, 8'h0A};  // n
      8'h72:   r = {2'b10, 8'h0D};  // r
      8'h74:   r = {2'b10, 8'h09};  // t
      8'h75:   r = {2'b11, 8'h00};  // u
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // True when n more bytes would reach the capacity
  function automatic logic no_room(logic [15:0] bw, logic [15:0] cap, logic [PW-1:0] n);
    return ({1'b0, bw} + 17'(n)) >= {1'b0, cap};
  endfunction

  // Length modulo PAD_ALIGN after adding n bytes
  function automatic logic [PW-1:0] mod_add(logic [PW-1:0] m, logic [1:0] n);
    logic [PW-1:0] s;
    s = m + PW'(n);
    for (int k = 0; k < 3; k++) begin
      if (s >= PW'(PAD_ALIGN)) s = s - PW'(PAD_ALIGN);
    end
    return s;
  endfunction

  phase_e        phase_q, phase_d;
  logic [1:0]    hc_q, hc_d;
  logic [15:0]   cp_q, cp_d;
  logic [15:0]   bw_q, bw_d;
  logic [15:0]   len_q, len_d;
  logic [PW-1:0] mod_q, mod_d;
  logic [15:0]   cap_q;

  logic          accept;
  logic [7:0]    c;
  logic [4:0]    hex;
  logic [9:0]    esc;
  logic [15:0]   cp_new;
  logic [1:0]    enc_n;
  logic [7:0]    enc_b [3];
  logic [PW-1:0] pad;
  logic [CNT_W-1:0] pad_emit;

  logic [CNT_W-1:0] lead_n;
  logic             lead_pad;
  logic [7:0]       lead_b [MAX_RES];
  logic             tail_v;
  kind_e            tail_kind;
  err_e             tail_err;
  logic             finished;
  jsu_burst_t       burst;
  logic             can_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = can_load;
  assign accept      = in_valid_i && in_ready_o;
  assign c           = in_data_i.in_byte;
  assign hex         = hex_value(c);
  assign esc         = esc_value(c);
  assign cp_new      = {cp_q[11:0], hex[3:0]};

  // UTF-8 encoding of the finished code point
  always_comb begin
    enc_b[1] = {2'b10, cp_new[5:0]};
    enc_b[2] = {2'b10, cp_new[5:0]};
    if (cp_new <= 16'h007F) begin
      enc_n    = 2'd1;
      enc_b[0] = cp_new[7:0];
    end else if (cp_new <= 16'h07FF) begin
      enc_n    = 2'd2;
      enc_b[0] = {3'b110, cp_new[10:6]};
    end else begin
      enc_n    = 2'd3;
      enc_b[0] = {4'hE, cp_new[15:12]};
      enc_b[1] = {2'b10, cp_new[11:6]};
    end
  end

  // Padding to the next multiple of PAD_ALIGN; emitted part is capped
  assign pad      = (mod_q == '0) ? '0 : PW'(PAD_ALIGN) - mod_q;
  assign pad_emit = (int'(pad) > MAX_RES - 1) ? CNT_W'(MAX_RES - 1) : CNT_W'(pad);

  // Decoder: next state and results of the current byte
  always_comb begin
    phase_d   = phase_q;
    hc_d      = hc_q;
    cp_d      = cp_q;
    bw_d      = bw_q;
    len_d     = len_q;
    mod_d     = mod_q;
    lead_n    = '0;
    lead_pad  = 1'b0;
    for (int k = 0; k < MAX_RES; k++) lead_b[k] = '0;
    tail_v    = 1'b0;
    tail_kind = KIND_ERROR;
    tail_err  = ERR_NONE;
    finished  = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (c != CH_QUOTE) begin
          tail_v   = 1'b1;
          tail_err = ERR_BAD_CHAR;
          finished = 1'b1;
        end else begin
          bw_d  = '0;
          len_d = '0;
          hc_d  = '0;
          cp_d  = '0;
          mod_d = '0;
          if (17'(HEADER_BYTES) >= {1'b0, cap_q}) begin
            tail_v   = 1'b1;
            tail_err = ERR_DST_OVF;
            finished = 1'b1;
          end else begin
            bw_d    = 16'(HEADER_BYTES);
            phase_d = PH_TEXT;
          end
        end
      end
      PH_HEX: begin
        if (!hex[4]) begin
          tail_v   = 1'b1;
          tail_err = ERR_BAD_UNI;
          finished = 1'b1;
          phase_d  = PH_IDLE;
        end else begin
          cp_d = cp_new;
          hc_d = hc_q + 2'd1;
          if (hc_q == 2'd3) begin
            phase_d = PH_TEXT;
            if (no_room(bw_q, cap_q, PW'(enc_n))) begin
              tail_v   = 1'b1;
              tail_err = ERR_DST_OVF;
              finished = 1'b1;
              phase_d  = PH_IDLE;
            end else begin
              lead_n    = CNT_W'(enc_n);
              lead_b[0] = enc_b[0];
              lead_b[1] = enc_b[1];
              lead_b[2] = enc_b[2];
              bw_d      = bw_q + 16'(enc_n);
              len_d     = len_q + 16'(enc_n);
              mod_d     = mod_add(mod_q, enc_n);
            end
          end
        end
      end
      PH_ESC: begin
        if (!esc[9]) begin
          tail_v   = 1'b1;
          tail_err = ERR_BAD_ESC;
          finished = 1'b1;
          phase_d  = PH_IDLE;
        end else if (esc[8]) begin
          cp_d    = '0;
          hc_d    = '0;
          phase_d = PH_HEX;
        end else if (no_room(bw_q, cap_q, PW'(1))) begin
          tail_v   = 1'b1;
          tail_err = ERR_DST_OVF;
          finished = 1'b1;
          phase_d  = PH_IDLE;
        end else begin
          phase_d   = PH_TEXT;
          lead_n    = CNT_W'(1);
          lead_b[0] = esc[7:0];
          bw_d      = bw_q + 16'd1;
          len_d     = len_q + 16'd1;
          mod_d     = mod_add(mod_q, 2'd1);
        end
      end
      default: begin
        if (c == CH_BSLASH) begin
          phase_d = PH_ESC;
        end else if (c == CH_QUOTE) begin
          // Closing quote: padding, then done, or an overflow error
          finished = 1'b1;
          tail_v   = 1'b1;
          phase_d  = PH_IDLE;
          if (no_room(bw_q, cap_q, pad)) begin
            tail_err = ERR_DST_OVF;
          end else begin
            lead_pad  = 1'b1;
            lead_n    = pad_emit;
            bw_d      = bw_q + 16'(pad);
            tail_kind = KIND_DONE;
          end
        end else if ((c < 8'h20 && c != CH_TAB) || c == CH_DEL) begin
          tail_v   = 1'b1;
          tail_err = ERR_BAD_CHAR;
          finished = 1'b1;
          phase_d  = PH_IDLE;
        end else if (no_room(bw_q, cap_q, PW'(1))) begin
          tail_v   = 1'b1;
          tail_err = ERR_DST_OVF;
          finished = 1'b1;
          phase_d  = PH_IDLE;
        end else begin
          lead_n    = CNT_W'(1);
          lead_b[0] = c;
          bw_d      = bw_q + 16'd1;
          len_d     = len_q + 16'd1;
          mod_d     = mod_add(mod_q, 2'd1);
        end
      end
    endcase

    // Source ran out before the string ended
    if (!finished && in_data_i.source_last) begin
      tail_v    = 1'b1;
      tail_kind = KIND_ERROR;
      tail_err  = ERR_SRC_OVF;
      phase_d   = PH_IDLE;
    end
  end

  // Lay the results out in order: lead bytes, then the tail item
  always_comb begin
    burst.count = lead_n + CNT_W'(tail_v);
    for (int i = 0; i < MAX_RES; i++) begin
      if (CNT_W'(i) < lead_n) begin
        burst.items[i].out_kind   = lead_pad ? KIND_PAD : KIND_DATA;
        burst.items[i].out_byte   = lead_pad ? 8'd0 : lead_b[i];
        burst.items[i].str_length = '0;
        burst.items[i].error_code = ERR_NONE;
      end else begin
        burst.items[i].out_kind   = tail_kind;
        burst.items[i].out_byte   = '0;
        burst.items[i].str_length = (tail_kind == KIND_DONE) ? len_q : 16'd0;
        burst.items[i].error_code = (tail_kind == KIND_DONE) ? ERR_NONE : tail_err;
      end
      burst.items[i].run_last = (CNT_W'(i) == burst.count - CNT_W'(1));
    end
  end

  // Decoder state and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hc_q    <= '0;
      cp_q    <= '0;
      bw_q    <= '0;
      len_q   <= '0;
      mod_q   <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        hc_q    <= hc_d;
        cp_q    <= cp_d;
        bw_q    <= bw_d;
        len_q   <= len_d;
        mod_q   <= mod_d;
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  jsu_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .burst_i    (burst),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // An item is taken only when no result is pending or the previous item's last result is leaving
  `JSU_ASSERT_IMP(a_accept_drained, accept,
                  !out_valid_o || (out_ready_i && out_data_o.run_last))
  // Done always closes the results of its byte
  `JSU_ASSERT_IMP(a_done_last, out_valid_o && (out_data_o.out_kind == KIND_DONE),
                  out_data_o.run_last)
  // Inside a string the destination holds exactly header plus decoded bytes
  `JSU_ASSERT_IMP(a_bw_track, phase_q != PH_IDLE,
                  bw_q == len_q + 16'(HEADER_BYTES))
  // The length modulo PAD_ALIGN stays below PAD_ALIGN after every accepted item
  `JSU_ASSERT_NXT(a_mod_range, accept, int'(mod_q) < PAD_ALIGN)

endmodule

@@ rtl/jsu_res_queue.sv @@
// Result queue: holds the results of one input item and hands them out in order.
// Depends on jsu_pkg.
module jsu_res_queue
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  jsu_burst_t burst_i,
  output logic       can_load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output jsu_out_t   out_data_o
);

  logic [CNT_W-1:0]       count_q, count_d;
  jsu_out_t [MAX_RES-1:0] items_q, items_d;
  logic                   pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = items_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // New burst fits when the queue is empty or its last pending result leaves this cycle
  assign can_load_o  = (count_q == '0) || ((count_q == CNT_W'(1)) && out_ready_i);

  // Load a burst or shift toward the head
  always_comb begin
    count_d = count_q;
    items_d = items_q;
    if (load_i) begin
      count_d = burst_i.count;
      items_d = burst_i.items;
    end else if (pop) begin
      count_d = count_q - CNT_W'(1);
      for (int k = 0; k < MAX_RES - 1; k++) begin
        items_d[k] = items_q[k + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    items_q <= items_d;
  end

endmodule

@@ verif/json_string_unescaper_checker.sv @@
// Checker for the JSON string unescaper: watches the input, result and config channels,
// predicts every result item from its own decoder model and compares them in order.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module json_string_unescaper_checker
  import jsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  jsu_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  jsu_out_t out_data_i,
  input  logic     cfg_valid_i,
  input  logic     cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int       errors_o,
  output int       pending_o,
  output logic     idle_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_TEXT = 2'd1,
    ST_ESC  = 2'd2,
    ST_HEX  = 2'd3
  } scan_e;

  // Decoder model state
  scan_e       scan;
  logic [1:0]  hex_seen;
  logic [15:0] code_pt;
  logic [15:0] used_bytes;
  logic [15:0] text_len;
  logic [15:0] capacity;

  jsu_out_t burst_q[$];
  jsu_out_t decoded_q[$];
  int       errors;
  int       pending;

  assign errors_o  = errors;
  assign pending_o = pending;
  assign idle_o    = (scan == ST_IDLE);

  // Append one result of the current byte; a byte never makes more than MAX_RES
  function automatic void add_result(kind_e k, logic [7:0] b, logic [15:0] l, err_e e);
    jsu_out_t r;
    if (burst_q.size() >= MAX_RES) return;
    r.out_kind   = k;
    r.out_byte   = b;
    r.str_length = l;
    r.error_code = e;
    r.run_last   = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void abort(err_e e);
    add_result(KIND_ERROR, 8'h00, 16'h0000, e);
    scan = ST_IDLE;
  endfunction

  // Destination must stay strictly below capacity
  function automatic bit fits(int n);
    if (used_bytes + n >= capacity) begin
      abort(ERR_DST_OVF);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    add_result(KIND_DATA, b, 16'h0000, ERR_NONE);
    used_bytes = used_bytes + 16'd1;
    text_len   = text_len + 16'd1;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - 8'h30;
    if (c >= "a" && c <= "f") return c - 8'h61 + 10;
    if (c >= "A" && c <= "F") return c - 8'h41 + 10;
    return -1;
  endfunction

  // One source byte in, its results appended to decoded_q
  function automatic void decode_byte(jsu_in_t it);
    logic [7:0] c;
    logic [7:0] esc_val;
    jsu_out_t   r;
    bit         finished;
    bit         esc_ok;
    bit         esc_u;
    int         d;
    int         pad;
    c        = it.in_byte;
    finished = 1'b0;
    esc_val  = 8'h00;
    esc_ok   = 1'b1;
    esc_u    = 1'b0;
    burst_q.delete();
    case (scan)
      ST_IDLE: begin
        if (c != "\"") begin
          abort(ERR_BAD_CHAR);
          finished = 1'b1;
        end else begin
          used_bytes = 16'd0;
          text_len   = 16'd0;
          hex_seen   = 2'd0;
          code_pt    = 16'd0;
          if (HEADER_BYTES_DEF >= capacity) begin
            abort(ERR_DST_OVF);
            finished = 1'b1;
          end else begin
            used_bytes = 16'(HEADER_BYTES_DEF);
            scan       = ST_TEXT;
          end
        end
      end
      ST_HEX: begin
        d = hex_val(c);
        if (d < 0) begin
          abort(ERR_BAD_UNI);
          finished = 1'b1;
        end else begin
          code_pt  = {code_pt[11:0], d[3:0]};
          hex_seen = hex_seen + 2'd1;
          if (hex_seen == 2'd0) begin
            scan = ST_TEXT;
            // UTF-8 in one to three bytes; surrogates go out as plain 3-byte forms
            if (code_pt <= 16'h007f) begin
              if (fits(1)) put_byte(code_pt[7:0]);
              else finished = 1'b1;
            end else if (code_pt <= 16'h07ff) begin
              if (fits(2)) begin
                put_byte({3'b110, code_pt[10:6]});
                put_byte({2'b10, code_pt[5:0]});
              end else finished = 1'b1;
            end else begin
              if (fits(3)) begin
                put_byte({4'b1110, code_pt[15:12]});
                put_byte({2'b10, code_pt[11:6]});
                put_byte({2'b10, code_pt[5:0]});
              end else finished = 1'b1;
            end
          end
        end
      end
      ST_ESC: begin
        case (c)
          "\"", "\\", "/": esc_val = c;
          "b": esc_val = 8'h08;
          "f": esc_val = 8'h0c;
          "n": esc_val = 8'h0a;
          "r": esc_val = 8'h0d;
          "t": esc_val = 8'h09;
          "u": esc_u = 1'b1;
          default: esc_ok = 1'b0;
        endcase
        if (!esc_ok) begin
          abort(ERR_BAD_ESC);
          finished = 1'b1;
        end else if (esc_u) begin
          code_pt  = 16'd0;
          hex_seen = 2'd0;
          scan     = ST_HEX;
        end else begin
          scan = ST_TEXT;
          if (fits(1)) put_byte(esc_val);
          else finished = 1'b1;
        end
      end
      default: begin
        if (c == "\\") begin
          scan = ST_ESC;
        end else if (c == "\"") begin
          // closing quote: pad to alignment, then the done item, or an overflow error
          finished = 1'b1;
          pad = (PAD_ALIGN_DEF - (text_len % PAD_ALIGN_DEF)) % PAD_ALIGN_DEF;
          if (fits(pad)) begin
            for (int k = 0; k < pad; k++) begin
              if (burst_q.size() < MAX_RES - 1) add_result(KIND_PAD, 8'h00, 16'h0000, ERR_NONE);
            end
            used_bytes = used_bytes + 16'(pad);
            add_result(KIND_DONE, 8'h00, text_len, ERR_NONE);
            scan = ST_IDLE;
          end
        end else if ((c < 8'h20 && c != 8'h09) || c == 8'h7f) begin
          abort(ERR_BAD_CHAR);
          finished = 1'b1;
        end else begin
          if (fits(1)) put_byte(c);
          else finished = 1'b1;
        end
      end
    endcase
    if (!finished && it.source_last) abort(ERR_SRC_OVF);
    if (burst_q.size() > 0) begin
      r = burst_q.pop_back();
      r.run_last = 1'b1;
      burst_q.push_back(r);
    end
    foreach (burst_q[i]) decoded_q.push_back(burst_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    jsu_out_t want;
    if (!rst_ni) begin
      scan       = ST_IDLE;
      hex_seen   = 2'd0;
      code_pt    = 16'd0;
      used_bytes = 16'd0;
      text_len   = 16'd0;
      capacity   = CAP_RESET;
      errors     = 0;
      decoded_q.delete();
      pending    = 0;
    end else begin
      // results leave before the item taken at this edge can add any
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result kind=%0d byte=%02h len=%0d err=%0d last=%0b",
                     $realtime, out_data_i.out_kind, out_data_i.out_byte,
                     out_data_i.str_length, out_data_i.error_code, out_data_i.run_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.out_kind !== want.out_kind || out_data_i.out_byte !== want.out_byte ||
              out_data_i.str_length !== want.str_length ||
              out_data_i.error_code !== want.error_code ||
              out_data_i.run_last !== want.run_last) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: result mismatch, expected kind=%0d byte=%02h len=%0d err=%0d ",
                        "last=%0b, got kind=%0d byte=%02h len=%0d err=%0d last=%0b"},
                       $realtime, want.out_kind, want.out_byte, want.str_length,
                       want.error_code, want.run_last, out_data_i.out_kind,
                       out_data_i.out_byte, out_data_i.str_length,
                       out_data_i.error_code, out_data_i.run_last);
          end
        end
      end
      // a byte taken at this edge still sees the old capacity
      if (in_valid_i && in_ready_i) decode_byte(in_data_i);
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      pending = decoded_q.size();
    end
  end

endmodule

@@ verif/json_string_unescaper_tb.sv @@
// Testbench top for the JSON string unescaper: clock, reset, directed and random
// source strings, capacity phases and the verdict. Depends on jsu_pkg and the checker.
`timescale 1ns / 1ps

module json_string_unescaper_tb;
  import jsu_pkg::*;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          NUM_PHASES    = 8;
  localparam int          CALM_PHASE    = 6;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  jsu_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  jsu_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = 16'h0000;

  int   fail_count;
  int   pending;
  logic dec_idle;
  bit   calm = 1'b0;
  int   items_sent = 0;

  jsu_in_t stream[$];

  // Capacity per phase and the least number of source bytes each one gets
  logic [15:0] cap_plan [0:NUM_PHASES-1] =
    '{16'hffff, 16'd0, 16'd8, 16'd9, 16'd16, 16'd30, 16'd64, 16'hffff};
  int item_plan [0:NUM_PHASES-1] = '{100, 15, 15, 30, 50, 60, 60, 80};

  json_string_unescaper dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  json_string_unescaper_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .errors_o    (fail_count),
    .pending_o   (pending),
    .idle_o      (dec_idle)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side stalls at random except in the calm phase
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  function automatic void queue_byte(logic [7:0] b, bit last);
    jsu_in_t t;
    t.in_byte     = b;
    t.source_last = last;
    stream.push_back(t);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'(n) - 8'd10;
    return 8'h41 + 8'(n) - 8'd10;
  endfunction

  function automatic void queue_unicode(logic [15:0] cp);
    queue_byte("\\", 1'b0);
    queue_byte("u", 1'b0);
    queue_byte(hex_char(cp[15:12]), 1'b0);
    queue_byte(hex_char(cp[11:8]), 1'b0);
    queue_byte(hex_char(cp[7:4]), 1'b0);
    queue_byte(hex_char(cp[3:0]), 1'b0);
  endfunction

  // One source string with random content; about one in five is broken at a random spot
  function automatic void build_string();
    int          n;
    int          pick;
    int          fault_at;
    int          digits;
    logic [7:0]  b;
    logic [15:0] cp;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    fault_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, n) : -1;
    if (fault_at == 0 && $urandom_range(0, 7) == 0) begin
      queue_byte("\"", 1'b1);
      return;
    end
    queue_byte("\"", 1'b0);
    for (int i = 0; i <= n; i++) begin
      if (i == fault_at) begin
        case ($urandom_range(0, 5))
          0: queue_byte(8'($urandom_range(8'h20, 8'h7e)) == "\"" ? "a" : "b", 1'b1);
          1: queue_byte("\\", 1'b1);
          2: begin
            queue_byte("\\", 1'b0);
            queue_byte("u", 1'b0);
            queue_byte(hex_char(4'($urandom_range(0, 15))), 1'b1);
          end
          3: begin
            // bad escape letter
            b = 8'($urandom_range(0, 255));
            case (b)
              "\"", "\\", "/", "b", "f", "n", "r", "t", "u": b = "x";
              default: ;
            endcase
            queue_byte("\\", 1'b0);
            queue_byte(b, 1'($urandom_range(0, 1)));
          end
          4: begin
            // non-hex digit inside a unicode escape
            digits = $urandom_range(0, 3);
            queue_byte("\\", 1'b0);
            queue_byte("u", 1'b0);
            for (int k = 0; k < digits; k++) queue_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
            b = 8'($urandom_range(0, 255));
            if ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
              b = "g";
            queue_byte(b, 1'($urandom_range(0, 1)));
          end
          default: begin
            // control byte or DEL
            b = ($urandom_range(0, 4) == 0) ? 8'h7f : 8'($urandom_range(0, 31));
            if (b == 8'h09) b = 8'h00;
            queue_byte(b, 1'($urandom_range(0, 1)));
          end
        endcase
        return;
      end
      if (i == n) break;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        b = 8'($urandom_range(8'h20, 8'h7e));
        if (b == "\"" || b == "\\") b = "a";
        queue_byte(b, 1'b0);
      end else if (pick < 55) begin
        queue_byte(8'($urandom_range(8'h80, 8'hff)), 1'b0);
      end else if (pick < 60) begin
        queue_byte(8'h09, 1'b0);
      end else if (pick < 78) begin
        queue_byte("\\", 1'b0);
        case ($urandom_range(0, 7))
          0: queue_byte("\"", 1'b0);
          1: queue_byte("\\", 1'b0);
          2: queue_byte("/", 1'b0);
          3: queue_byte("b", 1'b0);
          4: queue_byte("f", 1'b0);
          5: queue_byte("n", 1'b0);
          6: queue_byte("r", 1'b0);
          default: queue_byte("t", 1'b0);
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: cp = 16'($urandom_range(0, 16'h007f));
          1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
          2: cp = 16'($urandom_range(16'hd800, 16'hdfff));
          default: cp = 16'($urandom());
        endcase
        queue_unicode(cp);
      end
    end
    // closing quote may also be the end of the source
    queue_byte("\"", $urandom_range(0, 9) == 0);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(jsu_in_t it);
    if (!calm) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // With may_drop set, the rest of a string is dropped once the checker's model is back to idle
  task automatic send_stream(bit may_drop);
    jsu_in_t it;
    while (stream.size() > 0) begin
      it = stream.pop_front();
      send_item(it);
      if (may_drop && dec_idle) stream.delete();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cap(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int      start;
    jsu_in_t noise;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: bad bytes in idle, source ending at the quote, unicode forms
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b1);
    queue_byte("\"", 1'b1);
    queue_byte("\"", 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_unicode(16'hd800);
    queue_unicode(16'h07ff);
    queue_unicode(16'h0041);
    queue_byte("\"", 1'b0);
    send_stream(1'b0);

    // Random strings under a sequence of capacities
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_cap(cap_plan[p]);
      calm <= (p == CALM_PHASE);
      start = items_sent;
      while (items_sent - start < item_plan[p]) begin
        if ($urandom_range(0, 9) == 0) begin
          noise.in_byte     = 8'($urandom_range(0, 255));
          noise.source_last = 1'($urandom_range(0, 1));
          if (noise.in_byte == "\"") noise.in_byte = 8'h27;
          send_item(noise);
        end
        build_string();
        send_stream(1'b1);
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_res_queue.sv
rtl/json_string_unescaper.sv
verif/json_string_unescaper_checker.sv
verif/json_string_unescaper_tb.sv
